@@ rtl/core/fact_pkg.sv @@
package fact_pkg;

	localparam int unsigned COORD_WIDTH_DEF = 16;
	localparam int unsigned FRAC_BITS_DEF   = 8;
	localparam int unsigned NUM_AXES        = 3;
	localparam int unsigned NUM_PLANES      = 6;
	localparam int unsigned NUM_VP_ROWS     = 4;
	localparam int unsigned WORD_WIDTH      = 64;
	localparam int unsigned BOX_WIDTH       = 48;
	localparam int unsigned CFG_IDX_WIDTH   = 2;
	localparam int unsigned QUEUE_DEPTH     = 4;

endpackage

@@ rtl/core/frustum_aabb_cull_test.sv @@
// Throughput: one box per cycle while nothing stalls; the front stage set (corner
// products, min and max) and the back stage set (six plane products and sign) each
// take one item a cycle.
// A four-entry queue between them lets either side stall alone.
// Reset clears all valid flags and the view-projection rows to zero.
module frustum_aabb_cull_test import fact_pkg::*; #(
	parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [WORD_WIDTH-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [WORD_WIDTH-1:0]    model_row_x,
	input  logic [WORD_WIDTH-1:0]    model_row_y,
	input  logic [WORD_WIDTH-1:0]    model_row_z,
	input  logic [BOX_WIDTH-1:0]     box_min,
	input  logic [BOX_WIDTH-1:0]     box_max,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     visible
);

	localparam int unsigned WW = 2 * COORD_WIDTH + 4;
	localparam int unsigned DW = 2 * NUM_AXES * WW;

	logic [NUM_VP_ROWS-1:0][WORD_WIDTH-1:0] vp_q;
	logic fr_valid, fr_stall, bk_valid, bk_stall;
	logic signed [NUM_AXES-1:0][WW-1:0] fr_wmin, fr_wmax, bk_wmin, bk_wmax;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_q <= '0;
		end else if (cfg_valid) begin
			vp_q[cfg_index] <= cfg_data;
		end
	end

	fact_front #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.model_row_x, .model_row_y, .model_row_z, .box_min, .box_max,
		.fr_valid, .fr_stall, .fr_wmin, .fr_wmax
	);

	fact_queue #(.DW(DW)) u_queue (
		.clk, .arst_n,
		.wr_valid(fr_valid), .wr_stall(fr_stall), .wr_data({fr_wmax, fr_wmin}),
		.rd_valid(bk_valid), .rd_stall(bk_stall), .rd_data({bk_wmax, bk_wmin})
	);

	fact_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .bk_valid, .bk_stall, .bk_wmin, .bk_wmax,
		.vp_rows(vp_q), .out_valid, .out_stall, .visible
	);

endmodule

@@ rtl/core/fact_front.sv @@
module fact_front import fact_pkg::*; #(
	parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
	localparam int unsigned WW = 2 * COORD_WIDTH + 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [WORD_WIDTH-1:0]         model_row_x,
	input  logic [WORD_WIDTH-1:0]         model_row_y,
	input  logic [WORD_WIDTH-1:0]         model_row_z,
	input  logic [BOX_WIDTH-1:0]          box_min,
	input  logic [BOX_WIDTH-1:0]          box_max,
	output logic                          fr_valid,
	input  logic                          fr_stall,
	output logic signed [NUM_AXES-1:0][WW-1:0] fr_wmin,
	output logic signed [NUM_AXES-1:0][WW-1:0] fr_wmax
);

	localparam int unsigned PW = 2 * COORD_WIDTH;

	logic                                      v_s1;
	logic                                      v_s2;
	logic signed [NUM_AXES-1:0][2:0][PW-1:0]   plo_s1;
	logic signed [NUM_AXES-1:0][2:0][PW-1:0]   phi_s1;
	logic signed [NUM_AXES-1:0][WW-1:0]        tr_s1;
	logic signed [NUM_AXES-1:0][WW-1:0]        wmin_s2;
	logic signed [NUM_AXES-1:0][WW-1:0]        wmax_s2;
	logic                                      adv;
	logic [NUM_AXES-1:0][WORD_WIDTH-1:0]       mrow;

	function automatic logic signed [WW-1:0] min_ext(logic signed [PW-1:0] x,
		logic signed [PW-1:0] y);
		return (x < y) ? WW'(x) : WW'(y);
	endfunction

	function automatic logic signed [WW-1:0] max_ext(logic signed [PW-1:0] x,
		logic signed [PW-1:0] y);
		return (x < y) ? WW'(y) : WW'(x);
	endfunction

	assign mrow    = {model_row_z, model_row_y, model_row_x};
	assign adv     = !(v_s2 && fr_stall);
	assign in_stall = !adv;
	assign fr_valid = v_s2;
	assign fr_wmin  = wmin_s2;
	assign fr_wmax  = wmax_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				for (int c = 0; c < 3; c++) begin
					plo_s1[a][c] <= PW'(
						$signed(mrow[a][c*COORD_WIDTH +: COORD_WIDTH])
						* $signed(box_min[c*COORD_WIDTH +: COORD_WIDTH]));
					phi_s1[a][c] <= PW'(
						$signed(mrow[a][c*COORD_WIDTH +: COORD_WIDTH])
						* $signed(box_max[c*COORD_WIDTH +: COORD_WIDTH]));
				end
				tr_s1[a] <= WW'($signed(mrow[a][3*COORD_WIDTH +: COORD_WIDTH]))
					<<< FRAC_BITS;
			end
			for (int a = 0; a < NUM_AXES; a++) begin
				wmin_s2[a] <= $signed(tr_s1[a])
					+ min_ext(plo_s1[a][0], phi_s1[a][0])
					+ min_ext(plo_s1[a][1], phi_s1[a][1])
					+ min_ext(plo_s1[a][2], phi_s1[a][2]);
				wmax_s2[a] <= $signed(tr_s1[a])
					+ max_ext(plo_s1[a][0], phi_s1[a][0])
					+ max_ext(plo_s1[a][1], phi_s1[a][1])
					+ max_ext(plo_s1[a][2], phi_s1[a][2]);
			end
		end
	end

endmodule

@@ rtl/core/fact_queue.sv @@
module fact_queue import fact_pkg::*; #(
	parameter int unsigned DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_stall,
	input  logic [DW-1:0] wr_data,
	output logic          rd_valid,
	input  logic          rd_stall,
	output logic [DW-1:0] rd_data
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);

	logic [DW-1:0] mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW:0]   cnt_q;
	logic          push;
	logic          pop;

	assign wr_stall = (cnt_q == (AW+1)'(QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

endmodule

@@ rtl/core/fact_back.sv @@
module fact_back import fact_pkg::*; #(
	parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
	localparam int unsigned WW = 2 * COORD_WIDTH + 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               bk_valid,
	output logic                               bk_stall,
	input  logic signed [NUM_AXES-1:0][WW-1:0] bk_wmin,
	input  logic signed [NUM_AXES-1:0][WW-1:0] bk_wmax,
	input  logic [NUM_VP_ROWS-1:0][WORD_WIDTH-1:0] vp_rows,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               visible
);

	localparam int unsigned CW = COORD_WIDTH + 1;
	localparam int unsigned MW = WW + CW;
	localparam int unsigned AW = MW + 3;

	logic signed [NUM_PLANES-1:0][NUM_AXES:0][CW-1:0] pl;
	logic signed [NUM_PLANES-1:0][NUM_AXES:0][MW-1:0] prod_s1;
	logic [NUM_PLANES-1:0] neg;
	logic v_s1;
	logic v_s2;
	logic vis_s2;
	logic adv;

	assign adv       = !(v_s2 && out_stall);
	assign bk_stall  = !adv;
	assign out_valid = v_s2;
	assign visible   = vis_s2;

	always_comb begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			for (int c = 0; c <= NUM_AXES; c++) begin
				if (p % 2 == 1)
					pl[p][c] = CW'($signed(vp_rows[3][c*COORD_WIDTH +: COORD_WIDTH]))
						- CW'($signed(vp_rows[p/2][c*COORD_WIDTH +: COORD_WIDTH]));
				else
					pl[p][c] = CW'($signed(vp_rows[3][c*COORD_WIDTH +: COORD_WIDTH]))
						+ CW'($signed(vp_rows[p/2][c*COORD_WIDTH +: COORD_WIDTH]));
			end
		end
		for (int p = 0; p < NUM_PLANES; p++) begin
			neg[p] = (AW'($signed(prod_s1[p][0])) + AW'($signed(prod_s1[p][1]))
				+ AW'($signed(prod_s1[p][2])) + AW'($signed(prod_s1[p][3]))) < 0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= bk_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				for (int a = 0; a < NUM_AXES; a++)
					prod_s1[p][a] <= MW'($signed(pl[p][a]))
						* MW'(($signed(pl[p][a]) >= 0) ? $signed(bk_wmax[a])
						: $signed(bk_wmin[a]));
				prod_s1[p][3] <= MW'($signed(pl[p][3])) <<< (2 * FRAC_BITS);
			end
			vis_s2 <= (neg == '0);
		end
	end

endmodule
